// File: sv/sg3_pkg.sv
// shared types and constants for the 3x3 sobel gradient unit
package sg3_pkg;

   localparam int MaxWidth    = 1024;
   localparam int MaxHeight   = 4096;
   localparam int PixelBits   = 12;
   localparam int SumBits     = 15;
   localparam int ColBits     = $clog2(MaxWidth);
   localparam int RowBits     = $clog2(MaxHeight);
   localparam int WidthBits   = 11;
   localparam int HeightBits  = 13;
   localparam int CsrDataBits = 13;
   localparam int PendBits    = 11;

   typedef logic [PixelBits-1:0] pixel_type;
   typedef logic [ColBits-1:0]   col_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef struct packed {
      logic      rd_en;
      col_type   rd_addr;
      logic      wr_en;
      col_type   wr_addr;
      pixel_type wr_pixel;
   } lb_ctrl_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } lb_data_type;

endpackage

// File: sv/sg3_line_buffer.sv
// two line stores with registered read and same-address write forwarding
module sg3_line_buffer
   import sg3_pkg::*;
(
   input  logic        clock,
   input  lb_ctrl_type ctrl,
   output lb_data_type data
);

   pixel_type upper_mem  [MaxWidth];
   pixel_type middle_mem [MaxWidth];
   pixel_type upper_ff;
   pixel_type middle_ff;
   logic      fwd;

   // the word leaving the window stage writes the column the next word reads
   assign fwd = ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         upper_mem[ctrl.wr_addr]  <= middle_ff;
         middle_mem[ctrl.wr_addr] <= ctrl.wr_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         if (fwd) begin
            upper_ff  <= middle_ff;
            middle_ff <= ctrl.wr_pixel;
         end else begin
            upper_ff  <= upper_mem[ctrl.rd_addr];
            middle_ff <= middle_mem[ctrl.rd_addr];
         end
      end
   end

   assign data.upper  = upper_ff;
   assign data.middle = middle_ff;

endmodule

// File: sv/sobel_gradient_3x3_unit.sv
// top level of the 3x3 sobel gradient unit
// Takes one word per clock, sustained, whenever the result side keeps up: a
// word is registered together with its line-store read, and the 3x3 window and
// both sums are formed from those registers into the result register when the
// window stage advances, which a full result register not yet taken holds off.
// The result for a frame position comes out with the pixel one row plus one
// pixel later; drain words push out the trailing results after a frame.
// Border positions and frames narrower or shorter than three give zero sums.
// The line stores are block memories with no clearing pass and are usable
// straight after reset. A register write restarts the frame; the user must
// make it only while idle, and the block itself does not enforce this.
module sobel_gradient_3x3_unit
   import sg3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PixelBits-1:0]      req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SumBits-1:0] rsp_grad_x_sum,
   output logic signed [SumBits-1:0] rsp_grad_y_sum,
   output logic                      rsp_frame_end,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [CsrDataBits-1:0]    csr_write_data
);

   logic [WidthBits-1:0]  csr_width_ff;
   logic [HeightBits-1:0] csr_height_ff;
   logic [WidthBits-1:0]  eff_w;
   logic [HeightBits-1:0] eff_h;
   logic                  wr_width;
   logic                  wr_height;

   logic                  req_fire;
   logic                  req_is_pix;
   col_type               acol_ff;
   logic                  acol_last;

   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   pixel_type             s1_pixel_ff;
   logic                  s1_is_pix;
   logic                  s1_adv;
   logic                  emit;

   col_type               in_col_ff;
   logic [RowBits-1:0]    in_row_ff;
   logic                  in_last_col;
   logic                  in_last_row;
   logic [PendBits-1:0]   pending_ff;
   logic [PendBits-1:0]   pending_in;

   col_type               out_col_ff;
   logic [RowBits-1:0]    out_row_ff;
   logic                  out_last_col;
   logic                  out_last_row;
   logic                  inner;

   pixel_type             win_ff [3][3];
   pixel_type             win_in [3][3];

   logic signed [SumBits-1:0] tl, tc, tr, ml, mr, bl, bc, br;
   logic signed [SumBits-1:0] gx, gy;

   logic                      rsp_valid_ff;
   logic signed [SumBits-1:0] rsp_gx_ff;
   logic signed [SumBits-1:0] rsp_gy_ff;
   logic                      rsp_end_ff;

   lb_ctrl_type lb_ctrl;
   lb_data_type lb_data;

   function automatic logic signed [SumBits-1:0] ext(input pixel_type p);
      return signed'({{(SumBits-PixelBits){1'b0}}, p});
   endfunction

   // register writes
   always_comb begin
      wr_width  = 1'b0;
      wr_height = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  wr_width  = 1'b1;
            CSR_FRAME_HEIGHT: wr_height = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= WidthBits'(640);
         csr_height_ff <= HeightBits'(480);
      end else begin
         if (wr_width)  csr_width_ff  <= csr_write_data[WidthBits-1:0];
         if (wr_height) csr_height_ff <= csr_write_data[HeightBits-1:0];
      end
   end

   always_comb begin
      if (csr_width_ff == '0)                        eff_w = WidthBits'(1);
      else if (csr_width_ff > WidthBits'(MaxWidth))  eff_w = WidthBits'(MaxWidth);
      else                                           eff_w = csr_width_ff;
      if (csr_height_ff == '0)                         eff_h = HeightBits'(1);
      else if (csr_height_ff > HeightBits'(MaxHeight)) eff_h = HeightBits'(MaxHeight);
      else                                             eff_h = csr_height_ff;
   end

   // accept side: read address for the incoming word
   assign req_fire   = req_valid && req_ready;
   assign req_is_pix = opcode_type'(req_opcode) == OP_PIXEL;
   assign acol_last  = ({1'b0, acol_ff} + WidthBits'(1)) >= eff_w;

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         acol_ff <= '0;
      end else if (req_fire && req_is_pix) begin
         acol_ff <= acol_last ? '0 : acol_ff + col_type'(1);
      end
   end

   // window stage control
   assign s1_is_pix   = opcode_type'(s1_op_ff) == OP_PIXEL;
   assign in_last_col = ({1'b0, in_col_ff} + WidthBits'(1)) >= eff_w;
   assign in_last_row = ({1'b0, in_row_ff} + HeightBits'(1)) >= eff_h;

   always_comb begin
      if (s1_is_pix) emit = pending_ff > eff_w;
      else           emit = (in_col_ff == '0) && (in_row_ff == '0) && (pending_ff != '0);
   end

   assign s1_adv    = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_opcode;
         s1_pixel_ff <= req_pixel;
      end
   end

   assign lb_ctrl.rd_en    = req_fire && req_is_pix;
   assign lb_ctrl.rd_addr  = acol_ff;
   assign lb_ctrl.wr_en    = s1_adv && s1_is_pix;
   assign lb_ctrl.wr_addr  = in_col_ff;
   assign lb_ctrl.wr_pixel = s1_pixel_ff;

   sg3_line_buffer u_line_buffer (
      .clock (clock),
      .ctrl  (lb_ctrl),
      .data  (lb_data)
   );

   // window shift
   always_comb begin
      win_in = win_ff;
      if (s1_adv && s1_is_pix) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = lb_data.upper;
         win_in[1][2] = lb_data.middle;
         win_in[2][2] = s1_pixel_ff;
      end
   end

   always_comb begin
      if (!s1_is_pix)  pending_in = pending_ff - PendBits'(1);
      else if (emit)   pending_in = pending_ff;
      else             pending_in = pending_ff + PendBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         pending_ff <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff <= win_in;
         if (s1_is_pix || emit) pending_ff <= pending_in;
         if (s1_is_pix) begin
            if (in_last_col) begin
               in_col_ff <= '0;
               in_row_ff <= in_last_row ? '0 : in_row_ff + RowBits'(1);
            end else begin
               in_col_ff <= in_col_ff + col_type'(1);
            end
         end
      end
   end

   // output position and border test
   assign out_last_col = ({1'b0, out_col_ff} + WidthBits'(1)) >= eff_w;
   assign out_last_row = ({1'b0, out_row_ff} + HeightBits'(1)) >= eff_h;
   assign inner = (out_col_ff != '0) && (({1'b0, out_col_ff} + WidthBits'(2)) <= eff_w)
               && (out_row_ff != '0) && (({1'b0, out_row_ff} + HeightBits'(2)) <= eff_h);

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (s1_adv && emit) begin
         if (out_last_col) begin
            out_col_ff <= '0;
            out_row_ff <= out_last_row ? '0 : out_row_ff + RowBits'(1);
         end else begin
            out_col_ff <= out_col_ff + col_type'(1);
         end
      end
   end

   // sobel sums
   always_comb begin
      tl = ext(win_in[0][0]);
      tc = ext(win_in[0][1]);
      tr = ext(win_in[0][2]);
      ml = ext(win_in[1][0]);
      mr = ext(win_in[1][2]);
      bl = ext(win_in[2][0]);
      bc = ext(win_in[2][1]);
      br = ext(win_in[2][2]);
      gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
      gy = (bl - tl) + ((bc - tc) <<< 1) + (br - tr);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && emit) begin
         rsp_gx_ff  <= inner ? gx : '0;
         rsp_gy_ff  <= inner ? gy : '0;
         rsp_end_ff <= out_last_col && out_last_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_x_sum = rsp_gx_ff;
   assign rsp_grad_y_sum = rsp_gy_ff;
   assign rsp_frame_end  = rsp_end_ff;

   // pending words never exceed one row plus one pixel
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= eff_w + WidthBits'(1))
      else $error("pending count above row plus one");

   // read-side and window-side columns agree once the window stage is empty
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> acol_ff == in_col_ff)
      else $error("line store read column out of step");

   // output position stays inside the frame
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, out_col_ff} < eff_w) && ({1'b0, out_row_ff} < eff_h))
      else $error("output position outside frame");

   // a drain word only emits while something is pending
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && emit && !s1_is_pix |-> pending_ff != '0)
      else $error("drain emitted with nothing pending");

endmodule
